>>> rtl/core/sq_pkg.sv
package sq_pkg;

	// Number of cells in the queue.
	localparam int DEPTH = 16;

	localparam int VALUE_W = 32;

	// Internal occupancy counter must hold DEPTH itself.
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Width of the count field in a result.
	localparam int COUNT_W = 5;

	// Result packing on the master side.
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 4;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Operation broadcast to every cell in the same cycle.
	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_INS  = 2'd1,
		OP_REM  = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	// What one cell shows to its neighbors.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               valid;
		logic               less;
	} nbr_t;

endpackage

>>> rtl/core/sorted_min_priority_queue.sv
// Channel   Direction  tdata                    tuser
// s_axis    in         value[31:0]              req_type[0]
// m_axis    out        removed_value[31:0],     removed_valid[0], status[2:1],
//                      head_value[63:32],       head_valid[3]
//                      count[68:64]
//
// One transaction is taken per clock cycle unless the master side stalls. Every cell
// compares its entry with the broadcast value and looks only at its immediate neighbors,
// so an insert or a remove completes across the whole row in the cycle it is accepted.
// The result appears on the master side the cycle after acceptance, from a result register.
// Reset clears the cell valid bits and the count; stored values are not reset.
// A stall on the master side holds the result; a new request is taken while the
// result is being taken in the same cycle.
module sorted_min_priority_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// value[31:0]
	input  logic [sq_pkg::VALUE_W-1:0]    s_tdata,
	// req_type[0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// removed_value[31:0], head_value[63:32], count[68:64], zero fill above
	output logic [sq_pkg::OUT_DATA_W-1:0] m_tdata,
	// removed_valid[0], status[2:1], head_valid[3]
	output logic [sq_pkg::OUT_USER_W-1:0] m_tuser
);

	localparam int D = sq_pkg::DEPTH;
	localparam int W = sq_pkg::VALUE_W;
	localparam int CW = sq_pkg::CNT_W;

	logic                accept;
	logic                full;
	logic                empty;
	sq_pkg::cmd_t        cmd;
	sq_pkg::status_t     status;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_nxt;
	logic [W-1:0]        removed_value;
	logic                removed_valid;
	logic [W-1:0]        head_value;

	sq_pkg::nbr_t        cell_out [D];
	logic [W-1:0]        cell_nxt [D];
	logic [D-1:0]        valid_vec;

	// Result register.
	logic                out_valid_q;
	logic [W-1:0]        removed_value_q;
	logic                removed_valid_q;
	sq_pkg::status_t     status_q;
	logic [W-1:0]        head_value_q;
	logic                head_valid_q;
	logic [sq_pkg::COUNT_W-1:0] count_out_q;

	// The result register frees up whenever its contents are being taken.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign full  = (count_q == CW'(D));
	assign empty = (count_q == '0);

	// Decide the operation for the row. Dropped requests leave the cells alone.
	always_comb begin
		cmd.value     = s_tdata;
		cmd.op        = sq_pkg::OP_NONE;
		status        = sq_pkg::ST_OK;
		count_nxt     = count_q;
		removed_value = '0;
		removed_valid = 1'b0;
		if (accept) begin
			if (!s_tuser) begin
				if (full) begin
					status = sq_pkg::ST_FULL;
				end else begin
					cmd.op    = sq_pkg::OP_INS;
					count_nxt = CW'(count_q + CW'(1));
				end
			end else begin
				if (empty) begin
					status = sq_pkg::ST_EMPTY;
				end else begin
					cmd.op        = sq_pkg::OP_REM;
					count_nxt     = CW'(count_q - CW'(1));
					removed_value = cell_out[0].value;
					removed_valid = 1'b1;
				end
			end
		end
	end

	// The head after this request is what cell 0 loads at this edge.
	assign head_value = (count_nxt != '0) ? cell_nxt[0] : '0;

	genvar gi;
	generate
		for (gi = 0; gi < D; gi++) begin : g_cell
			sq_pkg::nbr_t left_n;
			sq_pkg::nbr_t right_n;

			if (gi == 0) begin : g_first
				// Nothing sits ahead of the first cell, so an insert lands here
				// unless this cell keeps its own entry.
				assign left_n = '{value: '0, valid: 1'b1, less: 1'b1};
			end else begin : g_mid
				assign left_n = cell_out[gi-1];
			end

			if (gi == D - 1) begin : g_last
				assign right_n = '{value: '0, valid: 1'b0, less: 1'b0};
			end else begin : g_rest
				assign right_n = cell_out[gi+1];
			end

			sq_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.left      (left_n),
				.right     (right_n),
				.own       (cell_out[gi]),
				.nxt_value (cell_nxt[gi])
			);

			assign valid_vec[gi] = cell_out[gi].valid;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			removed_value_q <= removed_value;
			removed_valid_q <= removed_valid;
			status_q        <= status;
			head_value_q    <= head_value;
			head_valid_q    <= (count_nxt != '0);
			count_out_q     <= sq_pkg::COUNT_W'(count_nxt);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, count_out_q, head_value_q, removed_value_q};
	assign m_tuser  = {head_valid_q, status_q, removed_valid_q};

	// The count never exceeds the number of cells.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(D))
		else $error("queue count above depth");

	// Occupied cells always match the count.
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(count_q))
		else $error("cell valid bits disagree with count");

	// A remove of a stored entry lowers the count by one.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == sq_pkg::OP_REM |=> count_q == CW'($past(count_q) - CW'(1)))
		else $error("count not lowered by remove");

	// A reported removal always comes with an ok status.
	a_removed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && removed_valid_q |-> status_q == sq_pkg::ST_OK)
		else $error("removal reported with error status");

endmodule

>>> rtl/core/sq_cell.sv
module sq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  sq_pkg::cmd_t      cmd,
	input  sq_pkg::nbr_t      left,
	input  sq_pkg::nbr_t      right,
	output sq_pkg::nbr_t      own,
	output logic [sq_pkg::VALUE_W-1:0] nxt_value
);

	logic [sq_pkg::VALUE_W-1:0] value_q;
	logic                       valid_q;
	logic                       nxt_valid;
	logic                       less;

	// A stored entry strictly below the new value stays where it is.
	assign less = valid_q && ($signed(value_q) < $signed(cmd.value));

	always_comb begin
		nxt_value = value_q;
		nxt_valid = valid_q;
		unique case (cmd.op)
			sq_pkg::OP_INS: begin
				if (less) begin
					nxt_value = value_q;
					nxt_valid = valid_q;
				end else if (left.less) begin
					nxt_value = cmd.value;
					nxt_valid = 1'b1;
				end else begin
					nxt_value = left.value;
					nxt_valid = left.valid;
				end
			end
			sq_pkg::OP_REM: begin
				nxt_value = right.value;
				nxt_valid = right.valid;
			end
			default: begin
				nxt_value = value_q;
				nxt_valid = valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= nxt_value;
	end

	assign own = '{value: value_q, valid: valid_q, less: less};

endmodule
